// ===== sv/ght_pkg.sv =====
// Shared types and constants for the generational handle table.
// Request/response structs, command and status codes, table geometry.
// No dependencies.
`default_nettype none

package ght_pkg;

  // table geometry
  localparam int INDEX_BITS = 8;
  localparam int GEN_BITS   = 16;
  localparam int DATA_BITS  = 48;
  localparam int CAP_BITS   = INDEX_BITS + 1;
  localparam int TABLE_SIZE = 1 << INDEX_BITS;
  localparam int ENTRY_BITS = GEN_BITS + DATA_BITS;

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_ERASE  = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_SET    = 3'd3;
  localparam logic [2:0] CMD_CHECK  = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_STALE = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]            command;
    logic [INDEX_BITS-1:0] handle_index;
    logic [GEN_BITS-1:0]   handle_generation;
    logic [DATA_BITS-1:0]  value_in;
  } ght_req_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] result_index;
    logic [GEN_BITS-1:0]   result_generation;
    logic [DATA_BITS-1:0]  value_out;
    logic                  handle_ok;
    logic [1:0]            status;
  } ght_rsp_t;

endpackage

`default_nettype wire

// ===== sv/generational_handle_table.sv =====
// Generational handle table: a request is taken only in the idle state,
// once the table is initialized. On acceptance the addressed entry (or the
// free-list head for insert) is read from the single table memory into a
// register; the exec state checks the handle, writes the entry back and
// loads the response register. After reset and after every capacity write,
// an initialization sweep over all 256 entries rebuilds the free chain, one
// entry per cycle, during which no request is taken. The response register
// frees the request side while a response waits. Depends on ght_pkg.
`default_nettype none

module generational_handle_table (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [8:0]       cfg_wdata_i,
  input  wire logic             req_valid_i,
  output logic                  req_stall_o,
  input  wire ght_pkg::ght_req_t req_i,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_stall_i,
  output ght_pkg::ght_rsp_t     rsp_o
);
  import ght_pkg::*;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CAP_BITS-1:0]   cap_q, cap_d;
  logic [INDEX_BITS-1:0] head_q, head_d;
  logic                  empty_q, empty_d;
  logic [INDEX_BITS-1:0] init_cnt_q, init_cnt_d;
  ght_req_t              req_q;
  logic [INDEX_BITS-1:0] addr_q;
  logic                  rsp_valid_q, rsp_valid_d;
  ght_rsp_t              rsp_q, rsp_d;

  logic [ENTRY_BITS-1:0] mem [TABLE_SIZE];
  logic [ENTRY_BITS-1:0] rd_data_q;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [INDEX_BITS-1:0] mem_raddr;
  logic                  req_fire;
  logic                  exec_go;

  logic [DATA_BITS-1:0]  rd_val;
  logic [GEN_BITS-1:0]   rd_gen;
  logic [CAP_BITS-1:0]   cap_m1;
  logic [CAP_BITS-1:0]   cfg_cap;
  logic                  in_range;
  logic                  gen_match;

  // handshake
  assign req_stall_o = (state_q != ST_IDLE);
  assign req_fire    = req_valid_i && !req_stall_o;
  assign exec_go     = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall_i);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // read address: free-list head for insert, handle index otherwise
  assign mem_raddr = (req_i.command == CMD_INSERT) ? head_q : req_i.handle_index;

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign rd_val    = rd_data_q[DATA_BITS-1:0];
  assign rd_gen    = rd_data_q[ENTRY_BITS-1:DATA_BITS];
  assign cap_m1    = cap_q - CAP_BITS'(1);
  assign in_range  = {1'b0, req_q.handle_index} < cap_q;
  assign gen_match = (rd_gen == req_q.handle_generation);

  // capacity clamp: zero or oversize selects the full table
  always_comb begin
    if (cfg_wdata_i == '0 || cfg_wdata_i > CAP_BITS'(TABLE_SIZE)) begin
      cfg_cap = CAP_BITS'(TABLE_SIZE);
    end else begin
      cfg_cap = cfg_wdata_i;
    end
  end

  // next state, memory write and response
  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    empty_d     = empty_q;
    init_cnt_d  = init_cnt_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = rd_data_q;

    unique case (state_q)
      ST_INIT: begin
        // rebuild the free chain, one entry per cycle
        mem_we    = 1'b1;
        mem_waddr = init_cnt_q;
        if ({1'b0, init_cnt_q} < cap_m1) begin
          mem_wdata = {{GEN_BITS{1'b0}}, DATA_BITS'({1'b0, init_cnt_q} + CAP_BITS'(1))};
        end else if ({1'b0, init_cnt_q} == cap_m1) begin
          mem_wdata = '1;
        end else begin
          mem_wdata = '0;
        end
        init_cnt_d = init_cnt_q + INDEX_BITS'(1);
        if (init_cnt_q == INDEX_BITS'(TABLE_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d                 = ST_IDLE;
          rsp_valid_d             = 1'b1;
          rsp_d.result_index      = req_q.handle_index;
          rsp_d.result_generation = req_q.handle_generation;
          rsp_d.value_out         = '0;
          rsp_d.handle_ok         = 1'b0;
          rsp_d.status            = STATUS_OK;
          if (req_q.command == CMD_INSERT) begin
            rsp_d.result_index      = '0;
            rsp_d.result_generation = '0;
            if (empty_q) begin
              rsp_d.status = STATUS_FULL;
            end else begin
              // pop the head, store the data word
              mem_we                  = 1'b1;
              mem_wdata               = {rd_gen, req_q.value_in};
              rsp_d.result_index      = addr_q;
              rsp_d.result_generation = rd_gen;
              rsp_d.handle_ok         = 1'b1;
              if (rd_val >= DATA_BITS'(cap_q)) begin
                empty_d = 1'b1;
              end else begin
                head_d = rd_val[INDEX_BITS-1:0];
              end
            end
          end else if (!in_range) begin
            rsp_d.status = STATUS_RANGE;
          end else if (!gen_match) begin
            rsp_d.status = STATUS_STALE;
          end else begin
            rsp_d.handle_ok = 1'b1;
            unique case (req_q.command)
              CMD_ERASE: begin
                // push back onto the free list, bump generation
                mem_we    = 1'b1;
                mem_wdata = {rd_gen + GEN_BITS'(1),
                             empty_q ? {DATA_BITS{1'b1}} : DATA_BITS'(head_q)};
                head_d    = addr_q;
                empty_d   = 1'b0;
              end
              CMD_GET: begin
                rsp_d.value_out = rd_val;
              end
              CMD_SET: begin
                mem_we    = 1'b1;
                mem_wdata = {rd_gen, req_q.value_in};
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase

    // capacity write restarts the sweep
    if (cfg_we_i) begin
      cap_d      = cfg_cap;
      head_d     = '0;
      empty_d    = 1'b0;
      init_cnt_d = '0;
      state_d    = ST_INIT;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cap_q       <= CAP_BITS'(TABLE_SIZE);
      head_q      <= '0;
      empty_q     <= 1'b0;
      init_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      empty_q     <= empty_d;
      init_cnt_q  <= init_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q  <= req_i;
      addr_q <= mem_raddr;
    end
    rsp_q <= rsp_d;
  end

endmodule

`default_nettype wire

// ===== sim/generational_handle_table_tb.sv =====
// Self-checking testbench for generational_handle_table: directed and random handle traffic
// across several capacity settings, with replies checked against a shadow of the table.
// Depends on ght_pkg and generational_handle_table.
`default_nettype none

module generational_handle_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ght_pkg::*;

  // command codes the table treats as check
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // shadow copies: one follows accepted requests, one steers stimulus
  localparam int CHECKER_COPY = 0;
  localparam int STIM_COPY    = 1;

  localparam int LONG_HOLD  = 200;
  localparam int REPORT_MAX = 10;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic [8:0]    cfg_wdata_i = '0;
  logic          req_valid_i = 1'b0;
  logic          req_stall_o;
  ght_req_t      req_i       = '0;
  logic          rsp_valid_o;
  logic          rsp_stall_i = 1'b0;
  ght_rsp_t      rsp_o;

  generational_handle_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // shadow table state
  logic [DATA_BITS-1:0]  tbl_data [2][TABLE_SIZE];
  logic [GEN_BITS-1:0]   tbl_gen  [2][TABLE_SIZE];
  logic [INDEX_BITS-1:0] tbl_head [2];
  logic                  tbl_empty[2];
  int                    tbl_cap  [2];

  ght_req_t op_queue[$];
  ght_rsp_t predicted_replies[$];
  int       live_list[$];

  ght_rsp_t reply;
  ght_rsp_t want;
  bit       idle_on = 1'b1;
  int       send_gap = 0;
  int       hold_left = 0;
  int       sent_count = 0;
  int       checked_count = 0;
  int       mismatches = 0;
  int       cfg_writes = 0;
  int       full_seen = 0;
  int       stale_seen = 0;
  int       range_seen = 0;

  // free chain rebuild after reset or a capacity write
  task automatic rebuild_table(input int c, input logic [CAP_BITS-1:0] v);
    int cap;
    cap = (v == 0 || v > TABLE_SIZE) ? TABLE_SIZE : int'(v);
    tbl_cap[c] = cap;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_data[c][i] = (i + 1 < cap) ? DATA_BITS'(i + 1) : '0;
      tbl_gen[c][i]  = '0;
    end
    tbl_data[c][cap-1] = '1;
    tbl_gen[c][cap-1]  = '1;
    tbl_head[c]  = '0;
    tbl_empty[c] = 1'b0;
  endtask

  // one request applied to a shadow copy, reply worked out
  task automatic table_step(input int c, input ght_req_t rq, output ght_rsp_t rs);
    logic [INDEX_BITS-1:0] h;
    logic [DATA_BITS-1:0]  link;
    rs = '0;
    rs.result_index      = rq.handle_index;
    rs.result_generation = rq.handle_generation;
    rs.status            = STATUS_OK;
    if (rq.command == CMD_INSERT) begin
      rs.result_index      = '0;
      rs.result_generation = '0;
      if (tbl_empty[c]) begin
        rs.status = STATUS_FULL;
      end else begin
        h    = tbl_head[c];
        link = tbl_data[c][h];
        // a link past the capacity ends the chain
        if (link >= DATA_BITS'(tbl_cap[c])) tbl_empty[c] = 1'b1;
        else tbl_head[c] = link[INDEX_BITS-1:0];
        tbl_data[c][h]       = rq.value_in;
        rs.result_index      = h;
        rs.result_generation = tbl_gen[c][h];
        rs.handle_ok         = 1'b1;
      end
    end else if (int'(rq.handle_index) >= tbl_cap[c]) begin
      rs.status = STATUS_RANGE;
    end else if (tbl_gen[c][rq.handle_index] != rq.handle_generation) begin
      rs.status = STATUS_STALE;
    end else begin
      rs.handle_ok = 1'b1;
      case (rq.command)
        CMD_ERASE: begin
          tbl_data[c][rq.handle_index] = tbl_empty[c] ? '1 : DATA_BITS'(tbl_head[c]);
          tbl_head[c]  = rq.handle_index;
          tbl_empty[c] = 1'b0;
          tbl_gen[c][rq.handle_index] = tbl_gen[c][rq.handle_index] + GEN_BITS'(1);
        end
        CMD_GET: rs.value_out = tbl_data[c][rq.handle_index];
        CMD_SET: tbl_data[c][rq.handle_index] = rq.value_in;
        default: ;
      endcase
    end
  endtask

  // queue a request and track which handles are live
  task automatic enqueue(input ght_req_t rq);
    ght_rsp_t rs;
    table_step(STIM_COPY, rq, rs);
    if (rs.handle_ok && rq.command == CMD_INSERT) begin
      live_list.push_back(int'(rs.result_index));
    end else if (rs.handle_ok && rq.command == CMD_ERASE) begin
      for (int k = 0; k < live_list.size(); k++) begin
        if (live_list[k] == int'(rq.handle_index)) begin
          live_list.delete(k);
          break;
        end
      end
    end
    op_queue.push_back(rq);
  endtask

  task automatic push_op(input logic [2:0] cmd, input logic [INDEX_BITS-1:0] idx,
                         input logic [GEN_BITS-1:0] gen, input logic [DATA_BITS-1:0] val);
    ght_req_t rq;
    rq.command           = cmd;
    rq.handle_index      = idx;
    rq.handle_generation = gen;
    rq.value_in          = val;
    enqueue(rq);
  endtask

  // random request: mostly well-formed handle traffic, the rest noise
  task automatic enqueue_random(input int ins_pct);
    ght_req_t rq;
    int roll;
    int pick;
    int cap;
    cap = tbl_cap[STIM_COPY];
    rq.command           = CMD_CHECK;
    rq.handle_index      = INDEX_BITS'($urandom);
    rq.handle_generation = GEN_BITS'($urandom);
    rq.value_in          = DATA_BITS'({$urandom, $urandom});
    roll = $urandom_range(0, 99);
    if (roll < ins_pct || (roll < 90 && live_list.size() == 0)) begin
      rq.command = CMD_INSERT;
    end else if (roll < 90) begin
      pick = live_list[$urandom_range(0, live_list.size() - 1)];
      rq.handle_index      = INDEX_BITS'(pick);
      rq.handle_generation = tbl_gen[STIM_COPY][pick];
      case ($urandom_range(0, 3))
        0:       rq.command = CMD_ERASE;
        1:       rq.command = CMD_GET;
        2:       rq.command = CMD_SET;
        default: rq.command = CMD_CHECK;
      endcase
    end else begin
      rq.command = 3'($urandom);
      case ($urandom_range(0, 3))
        // stale generation on an index in range
        1: begin
          rq.handle_index      = INDEX_BITS'($urandom_range(0, cap - 1));
          rq.handle_generation = tbl_gen[STIM_COPY][rq.handle_index]
                                 + GEN_BITS'($urandom_range(1, 3));
        end
        // index past the capacity
        2: if (cap < TABLE_SIZE) rq.handle_index = INDEX_BITS'($urandom_range(cap, TABLE_SIZE - 1));
        // current generation, live or free entry
        3: begin
          rq.handle_index      = INDEX_BITS'($urandom_range(0, cap - 1));
          rq.handle_generation = tbl_gen[STIM_COPY][rq.handle_index];
        end
        default: ;
      endcase
    end
    enqueue(rq);
  endtask

  // wait until every request is through and its reply is in
  task automatic drain();
    while (op_queue.size() != 0 || req_valid_i || predicted_replies.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [8:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rebuild_table(CHECKER_COPY, v);
    rebuild_table(STIM_COPY, v);
    live_list.delete();
    cfg_writes++;
  endtask

  task automatic run_phase(input logic [8:0] cap_value, input int items, input int ins_pct,
                           input bit idle);
    write_capacity(cap_value);
    idle_on = idle;
    repeat (items) enqueue_random(ins_pct);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
    end else begin
      // request taken: predict its reply
      if (req_valid_i && !req_stall_o) begin
        table_step(CHECKER_COPY, req_i, reply);
        predicted_replies.push_back(reply);
        sent_count++;
      end
      // offer the next request once the current one is gone
      if (!req_valid_i || !req_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid_i <= 1'b0;
        end else if (op_queue.size() != 0) begin
          req_i       <= op_queue.pop_front();
          req_valid_i <= 1'b1;
          send_gap = idle_on ? $urandom_range(0, 8) : 0;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // reply monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_stall_i <= 1'b0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i) begin
        checked_count++;
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("reply with no request pending: idx %0d gen %0d val %h ok %0d st %0d",
                     rsp_o.result_index, rsp_o.result_generation, rsp_o.value_out,
                     rsp_o.handle_ok, rsp_o.status);
        end else begin
          want = predicted_replies.pop_front();
          case (want.status)
            STATUS_FULL:  full_seen++;
            STATUS_STALE: stale_seen++;
            STATUS_RANGE: range_seen++;
            default: ;
          endcase
          if (rsp_o.result_index !== want.result_index ||
              rsp_o.result_generation !== want.result_generation ||
              rsp_o.value_out !== want.value_out ||
              rsp_o.handle_ok !== want.handle_ok ||
              rsp_o.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("reply %0d mismatch: expected idx %0d gen %0d val %h ok %0d st %0d, %s",
                       checked_count, want.result_index, want.result_generation,
                       want.value_out, want.handle_ok, want.status,
                       $sformatf("got idx %0d gen %0d val %h ok %0d st %0d",
                                 rsp_o.result_index, rsp_o.result_generation,
                                 rsp_o.value_out, rsp_o.handle_ok, rsp_o.status));
          end
        end
        // long hold-offs back the table up into its request side
        if (checked_count == 100 || checked_count == 700) hold_left = LONG_HOLD;
        else hold_left = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_left > 0) begin
        rsp_stall_i <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    rebuild_table(CHECKER_COPY, 9'd256);
    rebuild_table(STIM_COPY, 9'd256);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // full table after reset: free entry reads, insert, erase, reuse, spare codes
    push_op(CMD_CHECK,  8'd0,   16'h0000, '0);
    push_op(CMD_GET,    8'd255, 16'hFFFF, '0);
    push_op(CMD_INSERT, 8'd255, 16'hFFFF, '1);
    push_op(CMD_INSERT, 8'd0,   16'h0000, '0);
    push_op(CMD_GET,    8'd0,   16'h0000, '0);
    push_op(CMD_SET,    8'd1,   16'h0000, 48'hA5A5_5A5A_F00F);
    push_op(CMD_GET,    8'd1,   16'h0000, '0);
    push_op(CMD_ERASE,  8'd0,   16'h0000, '0);
    push_op(CMD_ERASE,  8'd0,   16'h0000, '0);
    push_op(CMD_GET,    8'd0,   16'h0001, '0);
    push_op(CMD_INSERT, 8'd0,   16'h0000, 48'h0000_0000_0001);
    push_op(CMD_CHECK,  8'd0,   16'hFFFF, '0);
    push_op(CMD_RSVD5,  8'd1,   16'h0000, '1);
    push_op(CMD_RSVD6,  8'd1,   16'h0000, '1);
    push_op(CMD_RSVD7,  8'd1,   16'h0000, '1);
    push_op(CMD_SET,    8'd255, 16'h0000, '1);

    // single entry: out of range, full table, generation wrap, erase onto empty list
    write_capacity(9'd1);
    push_op(CMD_GET,    8'd1,   16'h0000, '0);
    push_op(CMD_CHECK,  8'd255, 16'hFFFF, '0);
    push_op(CMD_INSERT, 8'd0,   16'h0000, 48'h8000_0000_0000);
    push_op(CMD_INSERT, 8'd0,   16'h0000, '1);
    push_op(CMD_ERASE,  8'd0,   16'hFFFF, '0);
    push_op(CMD_GET,    8'd0,   16'h0000, '0);
    push_op(CMD_INSERT, 8'd0,   16'h0000, 48'h0123_4567_89AB);
    push_op(CMD_ERASE,  8'd0,   16'h0000, '0);

    // random traffic over capacity settings, zero and oversize among them
    run_phase(9'd0,   400, 75, 1'b1);
    run_phase(9'd3,   150, 40, 1'b1);
    run_phase(9'd17,  150, 45, 1'b0);
    run_phase(9'd1,   100, 40, 1'b1);
    run_phase(9'd511, 100, 35, 1'b1);
    run_phase(9'd64,  150, 50, 1'b0);
    run_phase(9'd2,   100, 40, 1'b1);
    run_phase(9'd300, 100, 40, 1'b1);
    run_phase(9'd129, 100, 45, 1'b1);

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests over %0d capacity writes after reset", sent_count, cfg_writes);
    $display("replies: %0d table full, %0d stale, %0d out of range, %0d mismatches",
             full_seen, stale_seen, range_seen, mismatches);
    if (mismatches == 0 && predicted_replies.size() == 0)
      $display("generational_handle_table_tb: PASS");
    else
      $display("generational_handle_table_tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("generational_handle_table_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
